### hdl/yas_pkg.sv
`default_nettype none

package yas_pkg;

  localparam int PIX_W   = 8;
  localparam int VIEW_W  = 12;
  localparam int ROW_W   = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int ENTRY_W = 2 * VIEW_W;

  localparam int MAX_ROW_MACROPIXELS_DEF = 1024;
  localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(320);

  localparam logic signed [10:0] K_Y    = 11'sd298;
  localparam logic signed [10:0] K_RV   = 11'sd409;
  localparam logic signed [10:0] K_GU   = 11'sd100;
  localparam logic signed [10:0] K_GV   = 11'sd208;
  localparam logic signed [10:0] K_BU   = 11'sd516;
  localparam logic signed [19:0] K_RND  = 20'sd128;
  localparam logic signed [9:0]  Y_OFS  = 10'sd16;
  localparam logic signed [9:0]  C_OFS  = 10'sd128;
  localparam logic signed [11:0] CH_MAX = 12'sd255;

  typedef enum logic [0:0] {
    REG_BIN_MODE        = 1'b0,
    REG_ROW_MACROPIXELS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             frame_start;
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
  } pixel_t;

  typedef struct packed {
    logic [VIEW_W-1:0] left_first;
    logic [VIEW_W-1:0] right_first;
    logic [VIEW_W-1:0] left_second;
    logic [VIEW_W-1:0] right_second;
    logic              pair_valid;
  } result_t;

  typedef struct packed {
    logic             bin_mode;
    logic [ROW_W-1:0] row_macropixels;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/yas_cfg.sv
`default_nettype none

module yas_cfg (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [yas_pkg::PADDR_W-1:0] paddr,
  input  wire  [yas_pkg::PDATA_W-1:0] pwdata,
  output logic [yas_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output yas_pkg::cfg_t               cfg
);
  import yas_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bin_mode        <= 1'b0;
      cfg.row_macropixels <= ROW_RESET;
    end else if (wr) begin
      case (idx)
        REG_BIN_MODE:        cfg.bin_mode <= pwdata[0];
        REG_ROW_MACROPIXELS: cfg.row_macropixels <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BIN_MODE:        prdata = PDATA_W'(cfg.bin_mode);
      REG_ROW_MACROPIXELS: prdata = PDATA_W'(cfg.row_macropixels);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/yas_convert.sv
`default_nettype none

module yas_convert (
  input  wire  [yas_pkg::PIX_W-1:0]  luma,
  input  wire  [yas_pkg::PIX_W-1:0]  cb,
  input  wire  [yas_pkg::PIX_W-1:0]  cr,
  output logic [yas_pkg::VIEW_W-1:0] left_view,
  output logic [yas_pkg::VIEW_W-1:0] right_view
);
  import yas_pkg::*;

  logic signed [9:0]  c, d, e;
  logic signed [19:0] rs, gs, bs;
  logic [7:0]         r8, g8, b8;
  logic [8:0]         gb;

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic [7:0] res;
    if (v[11]) res = 8'd0;
    else if (v > CH_MAX) res = 8'd255;
    else res = v[7:0];
    return res;
  endfunction

  always_comb begin
    c  = signed'({2'b00, luma}) - Y_OFS;
    d  = signed'({2'b00, cb}) - C_OFS;
    e  = signed'({2'b00, cr}) - C_OFS;
    rs = K_Y * c + K_RV * e + K_RND;
    gs = K_Y * c - K_GU * d - K_GV * e + K_RND;
    bs = K_Y * c + K_BU * d + K_RND;
    r8 = clamp8(rs[19:8]);
    g8 = clamp8(gs[19:8]);
    b8 = clamp8(bs[19:8]);
    gb = {1'b0, g8} + {1'b0, b8};
    left_view  = {r8, 4'b0000};
    right_view = {gb, 3'b000};
  end

endmodule

`default_nettype wire

### hdl/yas_line_store.sv
`default_nettype none

module yas_line_store #(
  parameter int DEPTH = yas_pkg::MAX_ROW_MACROPIXELS_DEF
) (
  input  wire                         clk,
  input  wire                         we,
  input  wire                         re,
  input  wire  [$clog2(DEPTH)-1:0]    addr,
  input  wire  [yas_pkg::ENTRY_W-1:0] wdata,
  output logic [yas_pkg::ENTRY_W-1:0] rdata
);
  import yas_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### hdl/yuyv_anaglyph_splitter.sv
`default_nettype none

// YUYV to red/cyan anaglyph splitter. One macropixel word is taken per clock
// while pixel_stall is low; input throughput is one word per cycle in both
// modes, limited only by result_stall. The pipe is input register, BT.601
// conversion plus line store access, then averaging into the result register;
// each stage moves up when the next has room, so bubbles collapse. Binned even
// rows write the line store and produce no result word; odd rows read the entry
// at the same column. Row tracking follows row_macropixels (0 acts as 1, large
// values clamp to the store depth); frame_start restarts it. Configuration is
// written over APB at byte addresses 0 (bin_mode) and 4 (row_macropixels); the
// user must write it only while idle, which the block does not enforce.
module yuyv_anaglyph_splitter #(
  parameter int MAX_ROW_MACROPIXELS = yas_pkg::MAX_ROW_MACROPIXELS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [yas_pkg::PADDR_W-1:0] paddr,
  input  wire  [yas_pkg::PDATA_W-1:0] pwdata,
  output logic [yas_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  wire                         pixel_valid,
  output logic                        pixel_stall,
  input  yas_pkg::pixel_t             pixel,
  output logic                        result_valid,
  input  wire                         result_stall,
  output yas_pkg::result_t            result
);
  import yas_pkg::*;

  localparam int AW   = $clog2(MAX_ROW_MACROPIXELS);
  localparam int CMPW = (AW + 1 > ROW_W) ? AW + 1 : ROW_W;

  cfg_t cfg;

  yas_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // row tracking
  logic [AW-1:0]   col_count, col_count_next, cur_col;
  logic            odd_row, odd_row_next, cur_odd;
  logic [CMPW-1:0] rm_ext, max_ext, len, inc;
  logic            wrap, accept;

  // pipe control
  logic en1, en2, en_out;

  logic          s1_v, s1_bin, s1_odd;
  logic [AW-1:0] s1_col;
  pixel_t        s1_pix;

  logic              s2_v, s2_bin, s2_odd;
  logic [VIEW_W-1:0] s2_l0, s2_r0, s2_l1, s2_r1;

  logic [PIX_W:0]     luma_sum;
  logic [PIX_W-1:0]   luma_a;
  logic [VIEW_W-1:0]  cv_l0, cv_r0, cv_l1, cv_r1;
  logic               st_we, st_re;
  logic [ENTRY_W-1:0] st_rdata;
  logic [VIEW_W:0]    avg_l, avg_r;

  assign en_out      = !result_valid || !result_stall;
  assign en2         = !s2_v || en_out;
  assign en1         = !s1_v || en2;
  assign pixel_stall = !en1;
  assign accept      = pixel_valid && en1;

  always_comb begin
    rm_ext  = CMPW'(cfg.row_macropixels);
    max_ext = CMPW'(MAX_ROW_MACROPIXELS);
    if (rm_ext == '0) len = CMPW'(1);
    else if (rm_ext > max_ext) len = max_ext;
    else len = rm_ext;
    cur_col = pixel.frame_start ? '0 : col_count;
    cur_odd = pixel.frame_start ? 1'b0 : odd_row;
    inc     = CMPW'(cur_col) + CMPW'(1);
    wrap    = inc >= len;
    col_count_next = wrap ? '0 : inc[AW-1:0];
    odd_row_next   = wrap ? !cur_odd : cur_odd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      odd_row   <= 1'b0;
    end else if (accept) begin
      col_count <= col_count_next;
      odd_row   <= odd_row_next;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en1) begin
      s1_v <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixel;
      s1_bin <= cfg.bin_mode;
      s1_odd <= cur_odd;
      s1_col <= cur_col;
    end
  end

  assign luma_sum = {1'b0, s1_pix.luma_first} + {1'b0, s1_pix.luma_second};
  assign luma_a   = s1_bin ? luma_sum[PIX_W:1] : s1_pix.luma_first;

  yas_convert u_conv_a (
    .luma       (luma_a),
    .cb         (s1_pix.chroma_blue),
    .cr         (s1_pix.chroma_red),
    .left_view  (cv_l0),
    .right_view (cv_r0)
  );

  yas_convert u_conv_b (
    .luma       (s1_pix.luma_second),
    .cb         (s1_pix.chroma_blue),
    .cr         (s1_pix.chroma_red),
    .left_view  (cv_l1),
    .right_view (cv_r1)
  );

  assign st_we = en2 && s1_v && s1_bin && !s1_odd;
  assign st_re = en2 && s1_v && s1_bin && s1_odd;

  yas_line_store #(
    .DEPTH (MAX_ROW_MACROPIXELS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .re    (st_re),
    .addr  (s1_col),
    .wdata ({cv_l0, cv_r0}),
    .rdata (st_rdata)
  );

  // stage 2: converted pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en2) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v) begin
      s2_bin <= s1_bin;
      s2_odd <= s1_odd;
      s2_l0  <= cv_l0;
      s2_r0  <= cv_r0;
      s2_l1  <= cv_l1;
      s2_r1  <= cv_r1;
    end
  end

  assign avg_l = {1'b0, st_rdata[ENTRY_W-1:VIEW_W]} + {1'b0, s2_l0};
  assign avg_r = {1'b0, st_rdata[VIEW_W-1:0]} + {1'b0, s2_r0};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en_out) begin
      result_valid <= s2_v && (!s2_bin || s2_odd);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_v) begin
      if (s2_bin) begin
        result.left_first   <= avg_l[VIEW_W:1];
        result.right_first  <= avg_r[VIEW_W:1];
        result.left_second  <= '0;
        result.right_second <= '0;
        result.pair_valid   <= 1'b0;
      end else begin
        result.left_first   <= s2_l0;
        result.right_first  <= s2_r0;
        result.left_second  <= s2_l1;
        result.right_second <= s2_r1;
        result.pair_valid   <= 1'b1;
      end
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (s1_v && s2_v && result_valid && result_stall))
    else $error("input stalled while pipe has room");

  a_binned_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.pair_valid) |->
      (result.left_second == '0 && result.right_second == '0))
    else $error("binned word carries a second pixel");

  a_even_row_silent: assert property (@(posedge clk) disable iff (rst)
    (en_out && s2_v && s2_bin && !s2_odd) |=> !result_valid)
    else $error("binned even row produced a word");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && pixel.frame_start) |=> (col_count <= AW'(1)))
    else $error("frame start did not restart column tracking");

endmodule

`default_nettype wire

### test/tb_yuyv_anaglyph_splitter.sv
module tb_yuyv_anaglyph_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import yas_pkg::*;

  localparam int STORE_DEPTH  = MAX_ROW_MACROPIXELS_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int SEGMENTS     = 12;
  localparam int SEG_WORDS    = 112;
  localparam int SCRIPT_LEN   = 25;

  typedef struct packed {
    logic              is_cfg;
    reg_idx_t          idx;
    logic [ROW_W-1:0]  val;
    pixel_t            px;
    logic              typed;
    result_t           want;
  } step_t;

  localparam result_t BLACK_PAIR = '{12'd0, 12'd0, 12'd0, 12'd0, 1'b1};
  localparam result_t WHITE_PAIR = '{12'd4080, 12'd4080, 12'd4080, 12'd4080, 1'b1};

  step_t script [SCRIPT_LEN] = '{
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b1, 8'd16, 8'd128, 8'd16, 8'd128}, 1'b1, BLACK_PAIR},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd255, 8'd128, 8'd255, 8'd128}, 1'b1, WHITE_PAIR},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd0, 8'd128, 8'd0, 8'd128}, 1'b1, BLACK_PAIR},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd0, 8'd0, 8'd255, 8'd255}, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd255, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd235, 8'd16, 8'd16, 8'd240}, 1'b0, '0},
    '{1'b1, REG_BIN_MODE, 11'd1, '0, 1'b0, '0},
    '{1'b1, REG_ROW_MACROPIXELS, 11'd2, '0, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b1, 8'd200, 8'd30, 8'd91, 8'd220}, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd17, 8'd250, 8'd64, 8'd5}, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd255, 8'd0, 8'd254, 8'd255}, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd1, 8'd128, 8'd0, 8'd127}, 1'b0, '0},
    '{1'b1, REG_ROW_MACROPIXELS, 11'd0, '0, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd120, 8'd60, 8'd140, 8'd190}, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd90, 8'd200, 8'd33, 8'd70}, 1'b0, '0},
    '{1'b1, REG_ROW_MACROPIXELS, 11'd2047, '0, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b1, 8'd170, 8'd85, 8'd85, 8'd170}, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd85, 8'd170, 8'd170, 8'd85}, 1'b0, '0},
    '{1'b1, REG_ROW_MACROPIXELS, 11'd1, '0, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd240, 8'd15, 8'd15, 8'd240}, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd66, 8'd99, 8'd130, 8'd180}, 1'b0, '0},
    '{1'b1, REG_BIN_MODE, 11'd0, '0, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd50, 8'd240, 8'd210, 8'd10}, 1'b0, '0},
    '{1'b1, REG_BIN_MODE, 11'd1, '0, 1'b0, '0},
    '{1'b0, REG_BIN_MODE, 11'd0, '{1'b0, 8'd128, 8'd128, 8'd129, 8'd128}, 1'b0, '0}
  };

  logic             seg_mode [SEGMENTS] = '{0, 1, 1, 1, 0, 1, 1, 0, 1, 1, 1, 1};
  logic [ROW_W-1:0] seg_len  [SEGMENTS] = '{320, 1, 3, 8, 5, 16, 1024, 1024, 2, 0, 2047, 7};

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                pixel_valid = 1'b0;
  logic                pixel_stall;
  pixel_t              pixel = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result;

  // predictor state
  logic                view_mode = 1'b0;
  logic [ROW_W-1:0]    row_setting = ROW_RESET;
  int                  col_pos = 0;
  logic                odd_line = 1'b0;
  logic [ENTRY_W-1:0]  line_store [STORE_DEPTH];
  bit                  line_written [STORE_DEPTH];

  result_t             expected_views [$];
  int                  mismatch_count = 0;
  int                  idle_cycles = 0;
  int                  send_idle = 7;
  int                  recv_idle = 66;
  bit                  hold_req = 0;

  yuyv_anaglyph_splitter #(.MAX_ROW_MACROPIXELS(STORE_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clip255(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // {left, right} for one pixel
  function automatic logic [ENTRY_W-1:0] bt601_views(input logic [7:0] y, u, v);
    int c, d, e, r, g, b;
    c = int'(y) - 16;
    d = int'(u) - 128;
    e = int'(v) - 128;
    r = clip255((298 * c + 409 * e + 128) >>> 8);
    g = clip255((298 * c - 100 * d - 208 * e + 128) >>> 8);
    b = clip255((298 * c + 516 * d + 128) >>> 8);
    return {VIEW_W'(r << 4), VIEW_W'((g + b) << 3)};
  endfunction

  task automatic predict_views(input pixel_t w, output bit emits, output result_t calc);
    int                 span;
    logic [8:0]         luma_sum;
    logic [ENTRY_W-1:0] cur, kept;
    logic [VIEW_W:0]    sum_l, sum_r;
    emits = 0;
    calc = '0;
    span = (row_setting == 0) ? 1 : (row_setting > STORE_DEPTH ? STORE_DEPTH : row_setting);
    if (w.frame_start) begin
      col_pos = 0;
      odd_line = 1'b0;
    end
    if (!view_mode) begin
      {calc.left_first, calc.right_first} = bt601_views(w.luma_first, w.chroma_blue,
                                                        w.chroma_red);
      {calc.left_second, calc.right_second} = bt601_views(w.luma_second, w.chroma_blue,
                                                          w.chroma_red);
      calc.pair_valid = 1'b1;
      emits = 1;
    end else begin
      luma_sum = {1'b0, w.luma_first} + w.luma_second;
      cur = bt601_views(luma_sum[8:1], w.chroma_blue, w.chroma_red);
      if (!odd_line) begin
        line_store[col_pos] = cur;
        line_written[col_pos] = 1;
      end else begin
        kept = line_store[col_pos];
        sum_l = {1'b0, kept[ENTRY_W-1:VIEW_W]} + cur[ENTRY_W-1:VIEW_W];
        sum_r = {1'b0, kept[VIEW_W-1:0]} + cur[VIEW_W-1:0];
        calc.left_first = sum_l[VIEW_W:1];
        calc.right_first = sum_r[VIEW_W:1];
        emits = 1;
      end
    end
    col_pos++;
    if (col_pos >= span) begin
      col_pos = 0;
      odd_line = ~odd_line;
    end
  endtask

  task automatic send_word(input pixel_t w, input logic typed, input result_t want);
    bit      emits;
    result_t calc;
    while ($urandom_range(99) < send_idle) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel <= w;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    predict_views(w, emits, calc);
    if (emits) expected_views.push_back(typed ? want : calc);
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [ROW_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BIN_MODE) view_mode = val[0];
    else row_setting = val;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd235;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // result checker
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (expected_views.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, actual %p", $realtime, result);
        end else begin
          want = expected_views.pop_front();
          if (result.left_first !== want.left_first ||
              result.right_first !== want.right_first ||
              result.left_second !== want.left_second ||
              result.right_second !== want.right_second ||
              result.pair_valid !== want.pair_valid) begin
            mismatch_count++;
            $display("%0t: result mismatch, expected %p, actual %p",
                     $realtime, want, result);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("yuyv_anaglyph_splitter regression: fail");
        $finish;
      end
    end
  end

  initial begin
    pixel_t w;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_drained();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_word(script[i].px, script[i].typed, script[i].want);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin send_idle = 7;  recv_idle = 66; end
        1: begin send_idle = 66; recv_idle = 7;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      wait_drained();
      write_reg(REG_BIN_MODE, ROW_W'(seg_mode[seg]));
      write_reg(REG_ROW_MACROPIXELS, seg_len[seg]);
      if (seg == 0) hold_req = 1;
      for (int n = 0; n < SEG_WORDS; n++) begin
        w.frame_start = (n == 0) || ($urandom_range(49) == 0);
        w.luma_first = pick_byte();
        w.chroma_blue = pick_byte();
        w.luma_second = pick_byte();
        w.chroma_red = pick_byte();
        // an odd binned row may only read a column already stored
        if (view_mode && !w.frame_start && odd_line && !line_written[col_pos])
          w.frame_start = 1'b1;
        send_word(w, 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("yuyv_anaglyph_splitter regression: pass");
    else
      $display("yuyv_anaglyph_splitter regression: fail");
    $finish;
  end

endmodule
